// File: hw/rtl/lfxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_pkg: shared types and constants
// Queue entry layout, header byte codes and the key generator constants.
// ----------------------------------------------------------------------------
package lfxd_pkg;

  localparam int LEN_W = 24;

  // Position of the incoming byte within the four-byte header.
  localparam logic [1:0] HDR_LEN0 = 2'd0;
  localparam logic [1:0] HDR_LEN1 = 2'd1;
  localparam logic [1:0] HDR_LEN2 = 2'd2;
  localparam logic [1:0] HDR_SECT = 2'd3;

  localparam logic [31:0] LCG_SEED = 32'hDEADBEEF;
  localparam logic [31:0] LCG_MUL  = 32'd214013;
  localparam logic [31:0] LCG_INC  = 32'd2531011;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One classified result waiting for the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       xor_en;
    logic       last;
    logic       empty;
    logic       sticky;
  } entry_t;

endpackage

// File: hw/rtl/lfxd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lfxd_keygen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_keygen: key table fill after reset
// Steps the LCG once per cycle and writes one key byte per cycle into the
// key RAM, holding busy until the whole table is written.
// ----------------------------------------------------------------------------
module lfxd_keygen #(
  parameter int ROM_SIZE = 131072
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        busy,
  output logic                        we,
  output logic [$clog2(ROM_SIZE)-1:0] waddr,
  output logic [7:0]                  wdata
);

  localparam int AW = $clog2(ROM_SIZE);

  logic [31:0]   h;
  logic [31:0]   h_next;
  logic [AW-1:0] cnt;

  assign h_next = h * lfxd_pkg::LCG_MUL + lfxd_pkg::LCG_INC;

  assign we    = busy;
  assign waddr = cnt;
  assign wdata = h_next[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
      h    <= lfxd_pkg::LCG_SEED;
    end else if (busy) begin
      h   <= h_next;
      cnt <= cnt + 1'b1;
      if (cnt == AW'(ROM_SIZE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/lfxd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_front: header parser and byte classifier
// Gathers the four-byte header, tracks the remaining payload and decrypt
// counts and the key address, and pushes one entry per result.
// ----------------------------------------------------------------------------
module lfxd_front #(
  parameter int SECTION_COUNT  = 256,
  parameter int SECTION_LENGTH = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fill_busy,
  input  logic                   q_full,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  output logic                   push,
  output lfxd_pkg::entry_t       push_entry,
  output logic [$clog2(SECTION_COUNT * SECTION_LENGTH)-1:0] push_addr
);

  localparam int AW = $clog2(SECTION_COUNT * SECTION_LENGTH);
  localparam int OW = $clog2(SECTION_LENGTH);
  localparam int SW = $clog2(SECTION_COUNT);
  localparam int LW = lfxd_pkg::LEN_W;

  logic [1:0]    hcnt, hcnt_next;
  logic          in_payload, in_payload_next;
  logic [LW-1:0] hshift, hshift_next;
  logic [LW-1:0] bytes_left, bytes_left_next;
  logic [LW-1:0] decrypt_left, decrypt_left_next;
  logic [OW-1:0] offset, offset_next;
  logic [AW-1:0] addr, addr_next;
  logic [AW-1:0] base, base_next;
  logic          sticky, sticky_next;

  logic          accept;
  logic [16:0]   rem;
  logic [AW-1:0] sect_base;
  logic [LW:0]   dsum;
  logic [LW:0]   dround;
  logic [OW:0]   off_inc;
  logic          xor_now;

  assign in_ready = !fill_busy && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hcnt_next         = hcnt;
    in_payload_next   = in_payload;
    hshift_next       = hshift;
    bytes_left_next   = bytes_left;
    decrypt_left_next = decrypt_left;
    offset_next       = offset;
    addr_next         = addr;
    base_next         = base;
    sticky_next       = sticky;
    push              = 1'b0;
    push_entry        = '0;
    push_addr         = addr;
    xor_now           = decrypt_left != '0;

    // Section number modulo the section count, by restoring subtraction.
    rem = {9'b0, rx_byte};
    for (int i = 7; i >= 0; i--) begin
      if (rem >= (17'(SECTION_COUNT) << i)) begin
        rem = rem - (17'(SECTION_COUNT) << i);
      end
    end
    sect_base = AW'(SECTION_LENGTH) * AW'(rem[SW-1:0]);

    // Decrypted span: round (L + 4) down to a multiple of eight, minus four.
    dsum   = {1'b0, hshift} + (LW + 1)'(4);
    dround = {dsum[LW:3], 3'b000} - (LW + 1)'(4);

    off_inc = {1'b0, offset} + 1'b1;

    if (accept) begin
      if (!in_payload) begin
        case (hcnt)
          lfxd_pkg::HDR_LEN0: begin
            hshift_next[7:0] = rx_byte;
            hcnt_next        = lfxd_pkg::HDR_LEN1;
          end
          lfxd_pkg::HDR_LEN1: begin
            hshift_next[15:8] = rx_byte;
            hcnt_next         = lfxd_pkg::HDR_LEN2;
          end
          lfxd_pkg::HDR_LEN2: begin
            hshift_next[23:16] = rx_byte;
            hcnt_next          = lfxd_pkg::HDR_SECT;
          end
          default: begin
            hcnt_next       = lfxd_pkg::HDR_LEN0;
            hshift_next     = '0;
            bytes_left_next = hshift;
            base_next       = sect_base;
            addr_next       = sect_base + AW'(4);
            offset_next     = OW'(4);
            if (rx_byte != 8'd0) begin
              sticky_next       = 1'b1;
              decrypt_left_next = (hshift < LW'(4)) ? '0 : dround[LW-1:0];
            end else begin
              decrypt_left_next = '0;
            end
            if (hshift == '0) begin
              push              = 1'b1;
              push_entry.last   = 1'b1;
              push_entry.empty  = 1'b1;
              push_entry.sticky = sticky_next;
            end else begin
              in_payload_next = 1'b1;
            end
          end
        endcase
      end else begin
        push              = 1'b1;
        push_entry.data   = rx_byte;
        push_entry.xor_en = xor_now;
        push_entry.last   = bytes_left == LW'(1);
        push_entry.sticky = sticky;
        if (xor_now) begin
          decrypt_left_next = decrypt_left - 1'b1;
          if (off_inc == (OW + 1)'(SECTION_LENGTH)) begin
            offset_next = '0;
            addr_next   = base;
          end else begin
            offset_next = off_inc[OW-1:0];
            addr_next   = addr + 1'b1;
          end
        end
        bytes_left_next = bytes_left - 1'b1;
        if (bytes_left == LW'(1)) begin
          in_payload_next   = 1'b0;
          decrypt_left_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt         <= lfxd_pkg::HDR_LEN0;
      in_payload   <= 1'b0;
      hshift       <= '0;
      bytes_left   <= '0;
      decrypt_left <= '0;
      offset       <= '0;
      addr         <= '0;
      base         <= '0;
      sticky       <= 1'b0;
    end else begin
      hcnt         <= hcnt_next;
      in_payload   <= in_payload_next;
      hshift       <= hshift_next;
      bytes_left   <= bytes_left_next;
      decrypt_left <= decrypt_left_next;
      offset       <= offset_next;
      addr         <= addr_next;
      base         <= base_next;
      sticky       <= sticky_next;
    end
  end

endmodule

// File: hw/rtl/lfxd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_fifo: short queue between front and back end
// Four-entry register queue with full and non-empty flags.
// ----------------------------------------------------------------------------
module lfxd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = lfxd_pkg::QPTR_W;

  logic [WIDTH-1:0] store [lfxd_pkg::QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  assign full     = count == (PW + 1)'(lfxd_pkg::QDEPTH);
  assign nonempty = count != '0;
  assign rdata    = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/lfxd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfxd_back: key lookup and output stage
// Pops an entry, reads its key byte, and presents the result, XORed with the
// key byte when the entry asks for it, until it is taken.
// ----------------------------------------------------------------------------
module lfxd_back #(
  parameter int AW = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  lfxd_pkg::entry_t q_entry,
  input  logic [AW-1:0]    q_addr,
  output logic             pop,
  output logic             key_re,
  output logic [AW-1:0]    key_raddr,
  input  logic [7:0]       key_rdata,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_byte,
  output logic             last_of_message,
  output logic             empty_message,
  output logic             encrypted_mode
);

  lfxd_pkg::entry_t held;
  logic             held_valid;

  // The key RAM output only changes on a pop, so it holds with the entry.
  assign pop       = q_nonempty && (!held_valid || out_ready);
  assign key_re    = pop;
  assign key_raddr = q_addr;

  assign out_valid       = held_valid;
  assign data_byte       = held.data ^ (held.xor_en ? key_rdata : 8'd0);
  assign last_of_message = held.last;
  assign empty_message   = held.empty;
  assign encrypted_mode  = held.sticky;

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pop) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/length_framed_xor_table_decrypt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_xor_table_decrypt_top: framed stream decryptor
// Parses length/section headers and XORs payload bytes with a key table.
// ----------------------------------------------------------------------------
// After reset the block fills its key RAM with the LCG keystream, one entry
// per cycle, writing all SECTION_COUNT * SECTION_LENGTH entries (131072 at
// the defaults); in_ready stays low until the fill completes. Then it takes
// one received byte per cycle while the queue is not full: the header parser
// handles a byte in the cycle it arrives, and each result passes through the
// queue, then the output register, loaded with the registered key RAM read.
// A four-entry queue separates the parser from the output stage, so either
// side can stall without stopping the other until the queue fills.
// ----------------------------------------------------------------------------
module length_framed_xor_table_decrypt_top #(
  parameter int SECTION_COUNT  = 256,
  parameter int SECTION_LENGTH = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       last_of_message,
  output logic       empty_message,
  output logic       encrypted_mode
);

  localparam int ROM_SIZE = SECTION_COUNT * SECTION_LENGTH;
  localparam int AW       = $clog2(ROM_SIZE);
  localparam int EW       = $bits(lfxd_pkg::entry_t);

  logic             fill_busy;
  logic             fill_we;
  logic [AW-1:0]    fill_addr;
  logic [7:0]       fill_data;

  logic             push;
  lfxd_pkg::entry_t push_entry;
  logic [AW-1:0]    push_addr;
  logic             q_full;
  logic             q_nonempty;
  logic             pop;
  logic [AW+EW-1:0] q_rdata;
  lfxd_pkg::entry_t q_entry;
  logic [AW-1:0]    q_addr;

  logic             key_re;
  logic [AW-1:0]    key_raddr;
  logic [7:0]       key_rdata;

  assign q_entry = lfxd_pkg::entry_t'(q_rdata[EW-1:0]);
  assign q_addr  = q_rdata[AW+EW-1:EW];

  lfxd_keygen #(
    .ROM_SIZE(ROM_SIZE)
  ) u_keygen (
    .clk  (clk),
    .rst  (rst),
    .busy (fill_busy),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data)
  );

  lfxd_ram #(
    .WIDTH(8),
    .DEPTH(ROM_SIZE)
  ) u_key_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .re   (key_re),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  lfxd_front #(
    .SECTION_COUNT (SECTION_COUNT),
    .SECTION_LENGTH(SECTION_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .fill_busy (fill_busy),
    .q_full    (q_full),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_entry(push_entry),
    .push_addr (push_addr)
  );

  lfxd_fifo #(
    .WIDTH(AW + EW)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   ({push_addr, push_entry}),
    .full    (q_full),
    .pop     (pop),
    .nonempty(q_nonempty),
    .rdata   (q_rdata)
  );

  lfxd_back #(
    .AW(AW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_entry        (q_entry),
    .q_addr         (q_addr),
    .pop            (pop),
    .key_re         (key_re),
    .key_raddr      (key_raddr),
    .key_rdata      (key_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .last_of_message(last_of_message),
    .empty_message  (empty_message),
    .encrypted_mode (encrypted_mode)
  );

endmodule
